// ===== rtl/fpp_pkg.sv =====
// ============================================================================
// fpp_pkg - shared types and constants for the FEN position parser
// Character codes, board slots, status codes and the request/result records.
// ============================================================================
package fpp_pkg;

    // Width of the halfmove counter; it saturates at 2^CLOCK_WIDTH-1.
    localparam int CLOCK_WIDTH = 10;
    localparam int CLOCK_SUM_W = CLOCK_WIDTH + 4;

    localparam int NUM_BOARDS  = 8;
    localparam int PIECE_W     = 7;
    localparam int HALFMOVE_W  = 10;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_UC_K  = 8'h4B;
    localparam logic [7:0] CH_UC_Q  = 8'h51;
    localparam logic [7:0] CH_LC_K  = 8'h6B;
    localparam logic [7:0] CH_LC_Q  = 8'h71;
    localparam logic [7:0] CH_LC_R  = 8'h72;
    localparam logic [7:0] CH_LC_N  = 8'h6E;
    localparam logic [7:0] CH_LC_P  = 8'h70;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Board slots
    localparam logic [2:0] BD_WHITE  = 3'd0;
    localparam logic [2:0] BD_BLACK  = 3'd1;
    localparam logic [2:0] BD_KING   = 3'd2;
    localparam logic [2:0] BD_QUEEN  = 3'd3;
    localparam logic [2:0] BD_ROOK   = 3'd4;
    localparam logic [2:0] BD_BISHOP = 3'd5;
    localparam logic [2:0] BD_KNIGHT = 3'd6;
    localparam logic [2:0] BD_PAWN   = 3'd7;

    typedef enum logic [1:0] {
        ST_ACCEPT    = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_TOO_MANY  = 2'd2,
        ST_CASTLING  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       line_end;
    } in_item_t;

    typedef logic [63:0] board_t;

    typedef struct packed {
        status_t                        status;
        board_t [NUM_BOARDS-1:0]        boards;
        logic [4:0]                     move_flags;
        logic [5:0]                     passant_square;
        logic [HALFMOVE_W-1:0]          halfmove_clock;
    } result_t;

endpackage

// ===== rtl/fpp_in_stage.sv =====
// ============================================================================
// fpp_in_stage - input request register
// Holds one byte request; releases it when the parser can take it.
// ============================================================================
module fpp_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        text_byte,
    input  logic              line_end,
    input  logic              out_free,
    output logic              advance,
    output fpp_pkg::in_item_t item
);
    import fpp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // A line end needs a free result register; other bytes always go.
    assign advance  = valid_reg && (!item_reg.line_end || out_free);
    assign in_stall = valid_reg && !advance;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (!in_stall)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg.text_byte <= text_byte;
            item_reg.line_end  <= line_end;
        end
    end

endmodule

// ===== rtl/fpp_parser.sv =====
// ============================================================================
// fpp_parser - FEN parse state and per-byte update
// One byte per cycle while advance is high; on a line end forms the result and clears for the next.
// ============================================================================
module fpp_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  fpp_pkg::in_item_t            item,
    input  logic [fpp_pkg::PIECE_W-1:0]  max_pieces,
    output fpp_pkg::result_t             result
);
    import fpp_pkg::*;

    typedef enum logic [3:0] {
        PH_PLACE, PH_SLASH, PH_SP1, PH_SIDE, PH_SP2, PH_CAS0, PH_CASN, PH_SP3,
        PH_EP0, PH_EPR, PH_AFTEP, PH_CWS, PH_CSIGN, PH_CDIG, PH_DONE, PH_FAIL
    } phase_t;

    localparam logic [CLOCK_WIDTH-1:0] CLOCK_MAX = '1;

    phase_t                     phase_reg, phase_next, phase_tk;
    logic [2:0]                 rank_reg, rank_next, rank_tk;
    logic [3:0]                 file_reg, file_next, file_tk;
    board_t [NUM_BOARDS-1:0]    boards_reg, boards_next, boards_tk;
    logic [3:0]                 castle_reg, castle_next, castle_tk;
    logic                       side_reg, side_next, side_tk;
    logic [2:0]                 epf_reg, epf_next, epf_tk;
    logic [5:0]                 epi_reg, epi_next, epi_tk;
    logic [CLOCK_WIDTH-1:0]     clk_reg, clk_next, clk_tk;
    logic                       neg_reg, neg_next, neg_tk;
    logic [PIECE_W-1:0]         tally_reg, tally_next, tally_tk;
    logic                       bad_reg, bad_next, bad_tk;

    logic [7:0]                 c;
    logic                       is_digit;
    logic [CLOCK_SUM_W-1:0]     clk_sum;
    logic [3:0]                 castle_hot;
    logic                       piece_ok;
    logic [2:0]                 piece_slot;
    logic [2:0]                 color_slot;
    board_t                     square_bit;
    logic                       fin_bad;
    logic [CLOCK_WIDTH-1:0]     clk_out;
    logic [15:0]                clk_wide;

    function automatic logic end_ok(input phase_t ph);
        return ph == PH_AFTEP || ph == PH_CWS || ph == PH_CSIGN ||
               ph == PH_CDIG || ph == PH_DONE;
    endfunction

    assign c        = item.text_byte;
    assign is_digit = (c >= CH_0) && (c <= CH_9);
    assign clk_sum  = CLOCK_SUM_W'(clk_reg) * CLOCK_SUM_W'(10)
                    + CLOCK_SUM_W'(c[3:0]);

    // Piece letter decode, either case.
    always_comb
    begin
        piece_ok   = 1'b1;
        piece_slot = BD_KING;
        case (c | CASE_BIT)
            CH_LC_K: piece_slot = BD_KING;
            CH_LC_Q: piece_slot = BD_QUEEN;
            CH_LC_R: piece_slot = BD_ROOK;
            CH_B:    piece_slot = BD_BISHOP;
            CH_LC_N: piece_slot = BD_KNIGHT;
            CH_LC_P: piece_slot = BD_PAWN;
            default: piece_ok   = 1'b0;
        endcase
        color_slot = (c & CASE_BIT) != 8'h00 ? BD_BLACK : BD_WHITE;
        square_bit = board_t'(1) << {rank_reg, file_reg[2:0]};
    end

    always_comb
    begin
        case (c)
            CH_UC_K: castle_hot = 4'b0001;
            CH_UC_Q: castle_hot = 4'b0010;
            CH_LC_K: castle_hot = 4'b0100;
            CH_LC_Q: castle_hot = 4'b1000;
            default: castle_hot = 4'b0000;
        endcase
    end

    // Effect of one byte on the parse state.
    always_comb
    begin
        phase_tk  = phase_reg;
        rank_tk   = rank_reg;
        file_tk   = file_reg;
        boards_tk = boards_reg;
        castle_tk = castle_reg;
        side_tk   = side_reg;
        epf_tk    = epf_reg;
        epi_tk    = epi_reg;
        clk_tk    = clk_reg;
        neg_tk    = neg_reg;
        tally_tk  = tally_reg;
        bad_tk    = bad_reg;
        if (phase_reg != PH_FAIL && phase_reg != PH_DONE)
        begin
            if (c == CH_NUL)
            begin
                if (end_ok(phase_reg))
                begin
                    phase_tk = PH_DONE;
                end
                else
                begin
                    phase_tk = PH_FAIL;
                    bad_tk   = 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_PLACE:
                    begin
                        if (c >= CH_1 && c <= CH_8)
                        begin
                            file_tk = file_reg + c[3:0];
                        end
                        else if (!piece_ok || file_reg > 4'd7)
                        begin
                            phase_tk = PH_FAIL;
                            bad_tk   = 1'b1;
                        end
                        else
                        begin
                            boards_tk[piece_slot] = boards_reg[piece_slot] | square_bit;
                            boards_tk[color_slot] = boards_reg[color_slot] | square_bit;
                            tally_tk = tally_reg + PIECE_W'(1);
                            file_tk  = file_reg + 4'd1;
                        end
                        if (!bad_tk && file_tk >= 4'd8)
                        begin
                            if (file_tk != 4'd8)
                            begin
                                phase_tk = PH_FAIL;
                                bad_tk   = 1'b1;
                            end
                            else
                            begin
                                phase_tk = (rank_reg != 3'd0) ? PH_SLASH : PH_SP1;
                            end
                        end
                    end
                    PH_SLASH:
                    begin
                        if (c != CH_SLASH)
                        begin
                            phase_tk = PH_FAIL;
                            bad_tk   = 1'b1;
                        end
                        else
                        begin
                            rank_tk  = rank_reg - 3'd1;
                            file_tk  = 4'd0;
                            phase_tk = PH_PLACE;
                        end
                    end
                    PH_SP1, PH_SP2, PH_SP3:
                    begin
                        if (c != CH_SPACE)
                        begin
                            phase_tk = PH_FAIL;
                            bad_tk   = 1'b1;
                        end
                        else
                        begin
                            phase_tk = (phase_reg == PH_SP1) ? PH_SIDE
                                     : (phase_reg == PH_SP2) ? PH_CAS0 : PH_EP0;
                        end
                    end
                    PH_SIDE:
                    begin
                        if (c == CH_W || c == CH_B)
                        begin
                            side_tk  = (c == CH_W);
                            phase_tk = PH_SP2;
                        end
                        else
                        begin
                            phase_tk = PH_FAIL;
                            bad_tk   = 1'b1;
                        end
                    end
                    PH_CAS0, PH_CASN:
                    begin
                        if (phase_reg == PH_CAS0 && c == CH_DASH)
                        begin
                            phase_tk = PH_SP3;
                        end
                        else if (c == CH_SPACE)
                        begin
                            phase_tk = PH_EP0;
                        end
                        else if (castle_hot != 4'b0000)
                        begin
                            castle_tk = castle_reg | castle_hot;
                            phase_tk  = PH_CASN;
                        end
                        else
                        begin
                            phase_tk = PH_FAIL;
                            bad_tk   = 1'b1;
                        end
                    end
                    PH_EP0:
                    begin
                        if (c == CH_DASH)
                        begin
                            epi_tk   = 6'd0;
                            phase_tk = PH_AFTEP;
                        end
                        else if (c >= CH_A && c <= CH_H)
                        begin
                            epf_tk   = 3'(c - CH_A);
                            phase_tk = PH_EPR;
                        end
                        else
                        begin
                            phase_tk = PH_FAIL;
                            bad_tk   = 1'b1;
                        end
                    end
                    PH_EPR:
                    begin
                        if (c >= CH_1 && c <= CH_8)
                        begin
                            epi_tk   = {3'(c - CH_1), epf_reg};
                            phase_tk = PH_AFTEP;
                        end
                        else
                        begin
                            phase_tk = PH_FAIL;
                            bad_tk   = 1'b1;
                        end
                    end
                    PH_AFTEP:
                    begin
                        phase_tk = (c == CH_SPACE) ? PH_CWS : PH_DONE;
                    end
                    PH_CWS, PH_CSIGN, PH_CDIG:
                    begin
                        if (phase_reg == PH_CWS &&
                            (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
                        begin
                            phase_tk = PH_CWS;
                        end
                        else if (phase_reg == PH_CWS && (c == CH_PLUS || c == CH_DASH))
                        begin
                            neg_tk   = (c == CH_DASH);
                            phase_tk = PH_CSIGN;
                        end
                        else if (is_digit)
                        begin
                            clk_tk   = (clk_sum > CLOCK_SUM_W'(CLOCK_MAX))
                                     ? CLOCK_MAX : clk_sum[CLOCK_WIDTH-1:0];
                            phase_tk = PH_CDIG;
                        end
                        else
                        begin
                            phase_tk = PH_DONE;
                        end
                    end
                    default:
                    begin
                        phase_tk = phase_reg;
                    end
                endcase
            end
        end
    end

    // Result for a line end, taken from the post-byte state.
    always_comb
    begin
        fin_bad  = bad_tk || !end_ok(phase_tk);
        clk_out  = (neg_tk && clk_tk != '0) ? CLOCK_MAX : clk_tk;
        clk_wide = 16'(clk_out);
        result   = '0;
        if (fin_bad)
        begin
            result.status = ST_MALFORMED;
        end
        else
        begin
            if (tally_tk > max_pieces)
            begin
                result.status = ST_TOO_MANY;
            end
            else if (castle_tk != 4'b0000)
            begin
                result.status = ST_CASTLING;
            end
            else
            begin
                result.status = ST_ACCEPT;
            end
            result.boards         = boards_tk;
            result.move_flags     = {castle_tk, side_tk};
            result.passant_square = epi_tk;
            result.halfmove_clock = clk_wide[HALFMOVE_W-1:0];
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        rank_next   = rank_reg;
        file_next   = file_reg;
        boards_next = boards_reg;
        castle_next = castle_reg;
        side_next   = side_reg;
        epf_next    = epf_reg;
        epi_next    = epi_reg;
        clk_next    = clk_reg;
        neg_next    = neg_reg;
        tally_next  = tally_reg;
        bad_next    = bad_reg;
        if (advance && item.line_end)
        begin
            phase_next  = PH_PLACE;
            rank_next   = 3'd7;
            file_next   = 4'd0;
            boards_next = '0;
            castle_next = 4'd0;
            side_next   = 1'b0;
            epf_next    = 3'd0;
            epi_next    = 6'd0;
            clk_next    = '0;
            neg_next    = 1'b0;
            tally_next  = '0;
            bad_next    = 1'b0;
        end
        else if (advance)
        begin
            phase_next  = phase_tk;
            rank_next   = rank_tk;
            file_next   = file_tk;
            boards_next = boards_tk;
            castle_next = castle_tk;
            side_next   = side_tk;
            epf_next    = epf_tk;
            epi_next    = epi_tk;
            clk_next    = clk_tk;
            neg_next    = neg_tk;
            tally_next  = tally_tk;
            bad_next    = bad_tk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_PLACE;
            rank_reg   <= 3'd7;
            file_reg   <= 4'd0;
            boards_reg <= '0;
            castle_reg <= 4'd0;
            side_reg   <= 1'b0;
            epf_reg    <= 3'd0;
            epi_reg    <= 6'd0;
            clk_reg    <= '0;
            neg_reg    <= 1'b0;
            tally_reg  <= '0;
            bad_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            rank_reg   <= rank_next;
            file_reg   <= file_next;
            boards_reg <= boards_next;
            castle_reg <= castle_next;
            side_reg   <= side_next;
            epf_reg    <= epf_next;
            epi_reg    <= epi_next;
            clk_reg    <= clk_next;
            neg_reg    <= neg_next;
            tally_reg  <= tally_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

// ===== rtl/fen_position_parser.sv =====
// ============================================================================
// fen_position_parser - streaming FEN line parser producing bitboards
// Byte-per-cycle strict FEN parse with one result request per line.
// ============================================================================
// The block takes one character request per clock and, on the byte flagged
// with line_end, delivers one result request: a status code, eight 64-bit
// bitboards (white, black, then kings, queens, rooks, bishops, knights, pawns
// of both colors, a1 = bit 0), the move flags, the en-passant square and the
// halfmove clock. Throughput is one byte per cycle while the input is not
// stalled. Each byte passes the input register, then the parse state; a
// line_end byte loads the result register. The input stalls only while a
// line_end byte sits in the input register and a previous result still
// waits unread in the result register; ordinary bytes flow through the
// parse state regardless of the output side. The user must write max_pieces
// through cfg_we/cfg_wdata only while idle; the block does not enforce it.
// ============================================================================
module fen_position_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [fpp_pkg::PIECE_W-1:0]         cfg_wdata,
    // byte requests
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          text_byte,
    input  logic                                line_end,
    // result requests
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic [63:0]                         white_men,
    output logic [63:0]                         black_men,
    output logic [63:0]                         king_squares,
    output logic [63:0]                         queen_squares,
    output logic [63:0]                         rook_squares,
    output logic [63:0]                         bishop_squares,
    output logic [63:0]                         knight_squares,
    output logic [63:0]                         pawn_squares,
    output logic [4:0]                          move_flags,
    output logic [5:0]                          passant_square,
    output logic [fpp_pkg::HALFMOVE_W-1:0]      halfmove_clock
);
    import fpp_pkg::*;

    logic [PIECE_W-1:0] max_pieces_reg;
    logic [PIECE_W-1:0] max_pieces_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            result_reg;
    result_t            result_next;
    logic               out_free;
    logic               advance;
    in_item_t           item;
    logic               load_result;

    // Result register is free when empty or being drained this cycle.
    assign out_free    = !out_valid_reg || !out_stall;
    assign load_result = advance && item.line_end;

    fpp_in_stage u_in_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .text_byte (text_byte),
        .line_end  (line_end),
        .out_free  (out_free),
        .advance   (advance),
        .item      (item)
    );

    fpp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (item),
        .max_pieces (max_pieces_reg),
        .result     (result_next)
    );

    always_comb
    begin
        max_pieces_next = cfg_we ? cfg_wdata : max_pieces_reg;
        out_valid_next  = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pieces_reg <= PIECE_W'(7);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            max_pieces_reg <= max_pieces_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload holds unless a new result is loaded.
    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = result_reg.status;
    assign white_men      = result_reg.boards[BD_WHITE];
    assign black_men      = result_reg.boards[BD_BLACK];
    assign king_squares   = result_reg.boards[BD_KING];
    assign queen_squares  = result_reg.boards[BD_QUEEN];
    assign rook_squares   = result_reg.boards[BD_ROOK];
    assign bishop_squares = result_reg.boards[BD_BISHOP];
    assign knight_squares = result_reg.boards[BD_KNIGHT];
    assign pawn_squares   = result_reg.boards[BD_PAWN];
    assign move_flags     = result_reg.move_flags;
    assign passant_square = result_reg.passant_square;
    assign halfmove_clock = result_reg.halfmove_clock;

`ifndef SYNTHESIS
    // A malformed line carries an empty position.
    a_malformed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_MALFORMED |->
            white_men == 64'd0 && black_men == 64'd0 && move_flags == 5'd0)
        else $error("malformed result carries position data");

    // A square is never both white and black.
    a_color_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (white_men & black_men) == 64'd0)
        else $error("square occupied by both colors");

    // Accepted status means no castling rights.
    a_accept_no_castle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_ACCEPT |-> move_flags[4:1] == 4'd0)
        else $error("accepted result with castling rights");

    // Input side stalls only on a line end blocked by a held result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a held result");

    // A held result is never overwritten.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> !load_result)
        else $error("result register reloaded while stalled");
`endif

endmodule

// ===== dv/tb_fen_position_parser.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_fen_position_parser - self-checking bench for the FEN position parser
// Streams FEN lines a byte per request, predicts every result request with
// an in-bench parser and compares the result fields one by one.
// ============================================================================
// The bench has three processes around the block:
//   - a driver that pulls byte requests from a backlog queue at the falling
//     edge, with random sender gaps;
//   - a receiver that drives out_stall at the falling edge, random or held
//     off for a long stretch to fill the block;
//   - a monitor at the rising edge that feeds every accepted byte into the
//     predictor and checks every accepted result against the oldest
//     predicted position.
// The main process loads the backlog: a directed block of lines first, then
// random phases at different max_pieces settings and idle patterns.
// ============================================================================
module tb_fen_position_parser;

    import fpp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CLOCK_TOP = (1 << CLOCK_WIDTH) - 1;

    // castling right masks, K Q k q
    localparam logic [3:0] CASTLE_WK = 4'b0001;
    localparam logic [3:0] CASTLE_WQ = 4'b0010;
    localparam logic [3:0] CASTLE_BK = 4'b0100;
    localparam logic [3:0] CASTLE_BQ = 4'b1000;

    // parse position within a line
    typedef enum logic [3:0] {
        SCAN_BOARD, SCAN_SLASH, SCAN_GAP1, SCAN_SIDE, SCAN_GAP2,
        SCAN_CASTLE0, SCAN_CASTLEN, SCAN_GAP3, SCAN_EP_FILE, SCAN_EP_RANK,
        SCAN_AFTER_EP, SCAN_CLK_WS, SCAN_CLK_SIGN, SCAN_CLK_DIGIT,
        SCAN_DONE, SCAN_FAIL
    } scan_t;

    // ---------------------------------------------------------------- DUT I/O
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [PIECE_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] text_byte = '0;
    logic line_end = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] status;
    logic [63:0] white_men, black_men, king_squares, queen_squares;
    logic [63:0] rook_squares, bishop_squares, knight_squares, pawn_squares;
    logic [4:0] move_flags;
    logic [5:0] passant_square;
    logic [HALFMOVE_W-1:0] halfmove_clock;

    fen_position_parser uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .text_byte      (text_byte),
        .line_end       (line_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .white_men      (white_men),
        .black_men      (black_men),
        .king_squares   (king_squares),
        .queen_squares  (queen_squares),
        .rook_squares   (rook_squares),
        .bishop_squares (bishop_squares),
        .knight_squares (knight_squares),
        .pawn_squares   (pawn_squares),
        .move_flags     (move_flags),
        .passant_square (passant_square),
        .halfmove_clock (halfmove_clock)
    );

    // ------------------------------------------------------------ bench state
    in_item_t byte_backlog [$];     // byte requests not yet offered
    in_item_t next_req;
    logic [7:0] line_buf [$];       // line under construction
    result_t positions_due [$];     // predicted results, oldest first

    int bytes_queued = 0;           // written by the main process only
    int bytes_offered = 0;          // driver only
    int bytes_accepted = 0;         // monitor only
    int results_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_arm = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    string board_names [NUM_BOARDS] = '{"white_men", "black_men", "king_squares",
        "queen_squares", "rook_squares", "bishop_squares", "knight_squares",
        "pawn_squares"};

    // predictor copy of the parse state and of max_pieces
    scan_t scan = SCAN_BOARD;
    int rank_at = 7;
    int file_at = 0;
    board_t scan_boards [NUM_BOARDS];
    logic [3:0] castle_seen = '0;
    logic white_to_move = 1'b0;
    int ep_file = 0;
    logic [5:0] ep_index = '0;
    int clock_count = 0;
    logic clock_minus = 1'b0;
    logic [PIECE_W-1:0] men_count = '0;
    logic [PIECE_W-1:0] piece_limit = 7'd7;

    // -------------------------------------------------------------- predictor
    task automatic restart_scan();
        scan = SCAN_BOARD;
        rank_at = 7;
        file_at = 0;
        foreach (scan_boards[i])
            scan_boards[i] = '0;
        castle_seen = '0;
        white_to_move = 1'b0;
        ep_file = 0;
        ep_index = '0;
        clock_count = 0;
        clock_minus = 1'b0;
        men_count = '0;
    endtask

    // line may end once the en-passant field is complete
    function automatic bit may_end();
        return scan == SCAN_AFTER_EP || scan == SCAN_CLK_WS || scan == SCAN_CLK_SIGN ||
               scan == SCAN_CLK_DIGIT || scan == SCAN_DONE;
    endfunction

    function automatic int piece_slot(logic [7:0] c);
        case (c | CASE_BIT)
            CH_LC_K: return BD_KING;
            CH_LC_Q: return BD_QUEEN;
            CH_LC_R: return BD_ROOK;
            CH_B:    return BD_BISHOP;
            CH_LC_N: return BD_KNIGHT;
            CH_LC_P: return BD_PAWN;
            default: return -1;
        endcase
    endfunction

    function automatic logic [3:0] castle_mask(logic [7:0] c);
        case (c)
            CH_UC_K: return CASTLE_WK;
            CH_UC_Q: return CASTLE_WQ;
            CH_LC_K: return CASTLE_BK;
            CH_LC_Q: return CASTLE_BQ;
            default: return 4'b0000;
        endcase
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    task automatic take_clock_digit(logic [7:0] c);
        int v;
        v = clock_count * 10 + (c - CH_0);
        clock_count = (v > CLOCK_TOP) ? CLOCK_TOP : v;
        scan = SCAN_CLK_DIGIT;
    endtask

    // One accepted byte request; on line_end the expected position is queued.
    task automatic scan_char(logic [7:0] c, logic last);
        int slot;
        logic [3:0] cb;
        board_t sq;
        result_t r;
        if (scan != SCAN_DONE && scan != SCAN_FAIL)
        begin
            if (c == CH_NUL)
                scan = may_end() ? SCAN_DONE : SCAN_FAIL;
            else
            begin
                case (scan)
                    SCAN_BOARD:
                    begin
                        slot = piece_slot(c);
                        if (c >= CH_1 && c <= CH_8)
                            file_at = file_at + (c - CH_0);
                        else if (slot < 0 || file_at > 7)
                            scan = SCAN_FAIL;
                        else
                        begin
                            sq = 64'd1 << (rank_at * 8 + file_at);
                            scan_boards[slot] |= sq;
                            if ((c & CASE_BIT) != 0)
                                scan_boards[BD_BLACK] |= sq;
                            else
                                scan_boards[BD_WHITE] |= sq;
                            men_count = men_count + 1'b1;
                            file_at = file_at + 1;
                        end
                        // rank complete: exactly eight files, else malformed
                        if (scan != SCAN_FAIL && file_at >= 8)
                        begin
                            if (file_at != 8)
                                scan = SCAN_FAIL;
                            else
                                scan = (rank_at > 0) ? SCAN_SLASH : SCAN_GAP1;
                        end
                    end
                    SCAN_SLASH:
                    begin
                        if (c != CH_SLASH)
                            scan = SCAN_FAIL;
                        else
                        begin
                            rank_at = (rank_at - 1) & 7;
                            file_at = 0;
                            scan = SCAN_BOARD;
                        end
                    end
                    SCAN_GAP1:
                        scan = (c == CH_SPACE) ? SCAN_SIDE : SCAN_FAIL;
                    SCAN_SIDE:
                    begin
                        if (c == CH_W)
                        begin
                            white_to_move = 1'b1;
                            scan = SCAN_GAP2;
                        end
                        else if (c == CH_B)
                        begin
                            white_to_move = 1'b0;
                            scan = SCAN_GAP2;
                        end
                        else
                            scan = SCAN_FAIL;
                    end
                    SCAN_GAP2:
                        scan = (c == CH_SPACE) ? SCAN_CASTLE0 : SCAN_FAIL;
                    SCAN_CASTLE0, SCAN_CASTLEN:
                    begin
                        cb = castle_mask(c);
                        if (scan == SCAN_CASTLE0 && c == CH_DASH)
                            scan = SCAN_GAP3;
                        else if (c == CH_SPACE)
                            scan = SCAN_EP_FILE;    // also closes an empty field
                        else if (cb != 0)
                        begin
                            castle_seen |= cb;
                            scan = SCAN_CASTLEN;
                        end
                        else
                            scan = SCAN_FAIL;
                    end
                    SCAN_GAP3:
                        scan = (c == CH_SPACE) ? SCAN_EP_FILE : SCAN_FAIL;
                    SCAN_EP_FILE:
                    begin
                        if (c == CH_DASH)
                        begin
                            ep_index = '0;
                            scan = SCAN_AFTER_EP;
                        end
                        else if (c >= CH_A && c <= CH_H)
                        begin
                            ep_file = c - CH_A;
                            scan = SCAN_EP_RANK;
                        end
                        else
                            scan = SCAN_FAIL;
                    end
                    SCAN_EP_RANK:
                    begin
                        if (c >= CH_1 && c <= CH_8)
                        begin
                            ep_index = 6'(((c - CH_1) * 8 + ep_file) & 63);
                            scan = SCAN_AFTER_EP;
                        end
                        else
                            scan = SCAN_FAIL;
                    end
                    SCAN_AFTER_EP:
                        scan = (c == CH_SPACE) ? SCAN_CLK_WS : SCAN_DONE;
                    SCAN_CLK_WS:
                    begin
                        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                            scan = SCAN_CLK_WS;
                        else if (c == CH_PLUS || c == CH_DASH)
                        begin
                            clock_minus = (c == CH_DASH);
                            scan = SCAN_CLK_SIGN;
                        end
                        else if (is_digit(c))
                            take_clock_digit(c);
                        else
                            scan = SCAN_DONE;
                    end
                    SCAN_CLK_SIGN, SCAN_CLK_DIGIT:
                    begin
                        if (is_digit(c))
                            take_clock_digit(c);
                        else
                            scan = SCAN_DONE;
                    end
                    default: ;
                endcase
            end
        end

        if (last)
        begin
            if (scan != SCAN_FAIL && !may_end())
                scan = SCAN_FAIL;
            r = '0;
            if (scan == SCAN_FAIL)
                r.status = ST_MALFORMED;
            else
            begin
                if (men_count > piece_limit)
                    r.status = ST_TOO_MANY;
                else if (castle_seen != 0)
                    r.status = ST_CASTLING;
                else
                    r.status = ST_ACCEPT;
                for (int i = 0; i < NUM_BOARDS; i++)
                    r.boards[i] = scan_boards[i];
                r.move_flags = {castle_seen, white_to_move};
                r.passant_square = ep_index;
                // a minus sign on a nonzero count saturates
                r.halfmove_clock = HALFMOVE_W'((clock_minus && clock_count != 0)
                                               ? CLOCK_TOP : clock_count);
            end
            positions_due.push_back(r);
            restart_scan();
        end
    endtask

    // ---------------------------------------------------------------- checker
    task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t: result %0d %s: got %h, want %h", $realtime, results_seen,
                 what, got, want);
        mismatches++;
    endtask

    task automatic check_position();
        result_t want;
        board_t got [NUM_BOARDS];
        if (positions_due.size() == 0)
        begin
            note_mismatch("result with no line pending", 64'(status), 64'd0);
            return;
        end
        want = positions_due.pop_front();
        got[BD_WHITE] = white_men;
        got[BD_BLACK] = black_men;
        got[BD_KING] = king_squares;
        got[BD_QUEEN] = queen_squares;
        got[BD_ROOK] = rook_squares;
        got[BD_BISHOP] = bishop_squares;
        got[BD_KNIGHT] = knight_squares;
        got[BD_PAWN] = pawn_squares;
        if (status !== want.status)
            note_mismatch("status", 64'(status), 64'(want.status));
        for (int i = 0; i < NUM_BOARDS; i++)
            if (got[i] !== want.boards[i])
                note_mismatch(board_names[i], got[i], want.boards[i]);
        if (move_flags !== want.move_flags)
            note_mismatch("move_flags", 64'(move_flags), 64'(want.move_flags));
        if (passant_square !== want.passant_square)
            note_mismatch("passant_square", 64'(passant_square),
                          64'(want.passant_square));
        if (halfmove_clock !== want.halfmove_clock)
            note_mismatch("halfmove_clock", 64'(halfmove_clock),
                          64'(want.halfmove_clock));
    endtask

    // -------------------------------------------------------- line generation
    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // move the finished line to the backlog, line_end on its final byte
    task automatic close_line();
        in_item_t req;
        foreach (line_buf[i])
        begin
            req.text_byte = line_buf[i];
            req.line_end = (i == line_buf.size() - 1);
            byte_backlog.push_back(req);
        end
        bytes_queued += line_buf.size();
        line_buf.delete();
    endtask

    // empty run split into a random number of digits
    task automatic add_gap(int gap);
        int d;
        while (gap > 0)
        begin
            d = $urandom_range(gap, 1);
            line_buf.push_back(8'(CH_0 + d));
            gap -= d;
        end
    endtask

    task automatic build_fen();
        string men;
        string rights;
        int density;
        int gap;
        int n;
        men = "KQRBNPkqrbnp";
        rights = "KQkq";
        // density per line; empty boards keep the accepted status reachable
        case ($urandom_range(3))
            0: density = 0;
            1: density = 5;
            2: density = 15;
            default: density = $urandom_range(100);
        endcase
        for (int r = 7; r >= 0; r--)
        begin
            gap = 0;
            for (int f = 0; f < 8; f++)
            begin
                if ($urandom_range(99) < density)
                begin
                    add_gap(gap);
                    gap = 0;
                    line_buf.push_back(men[$urandom_range(11)]);
                end
                else
                    gap++;
            end
            add_gap(gap);
            if (r > 0)
                line_buf.push_back(CH_SLASH);
        end
        line_buf.push_back(CH_SPACE);
        line_buf.push_back($urandom_range(1) ? CH_W : CH_B);
        line_buf.push_back(CH_SPACE);
        case ($urandom_range(5))
            0, 1, 2: line_buf.push_back(CH_DASH);
            3: ;    // empty castling field
            default:
            begin
                n = $urandom_range(4, 1);
                repeat (n)
                    line_buf.push_back(rights[$urandom_range(3)]);
            end
        endcase
        line_buf.push_back(CH_SPACE);
        if ($urandom_range(1))
            line_buf.push_back(CH_DASH);
        else
        begin
            line_buf.push_back(8'(CH_A + $urandom_range(7)));
            line_buf.push_back(8'(CH_1 + $urandom_range(7)));
        end
        case ($urandom_range(5))
            0: ;    // line ends on the en-passant field
            1:
            begin
                // trailing text glued to the en-passant field
                line_buf.push_back($urandom_range(1) ? CH_PLUS : 8'($urandom_range(255, 33)));
                repeat ($urandom_range(3))
                    line_buf.push_back(8'($urandom_range(255)));
            end
            5:
            begin
                line_buf.push_back(CH_NUL);
                repeat ($urandom_range(4))
                    line_buf.push_back(8'($urandom_range(255)));
            end
            default:
            begin
                line_buf.push_back(CH_SPACE);
                repeat ($urandom_range(2))
                    line_buf.push_back($urandom_range(5) == 0 ? CH_SPACE
                                                              : 8'(CH_TAB + $urandom_range(4)));
                case ($urandom_range(3))
                    0: line_buf.push_back(CH_PLUS);
                    1: line_buf.push_back(CH_DASH);
                    default: ;
                endcase
                repeat ($urandom_range(5))
                    line_buf.push_back(8'(CH_0 + $urandom_range(9)));
                repeat ($urandom_range(3))
                    line_buf.push_back(8'($urandom_range(255)));
            end
        endcase
    endtask

    // mostly well-formed lines, some corrupted, some pure noise
    task automatic queue_random_line();
        int kind;
        int pos;
        int keep;
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            repeat ($urandom_range(16, 1))
                line_buf.push_back(8'($urandom_range(255)));
        end
        else
        begin
            build_fen();
            pos = $urandom_range(line_buf.size() - 1);
            if (kind < 17)
                line_buf[pos] = 8'($urandom_range(255));
            else if (kind < 22)
            begin
                keep = $urandom_range(line_buf.size() - 1, 1);
                while (line_buf.size() > keep)
                    void'(line_buf.pop_back());
            end
            else if (kind < 25)
                line_buf.insert(pos, 8'($urandom_range(255)));
        end
        close_line();
    endtask

    task automatic run_lines(int min_bytes, int min_lines);
        int start_bytes;
        int lines;
        start_bytes = bytes_queued;
        lines = 0;
        while (bytes_queued - start_bytes < min_bytes || lines < min_lines)
        begin
            queue_random_line();
            lines++;
        end
    endtask

    // ------------------------------------------------------- phase sequencing
    // idle: every byte taken and every predicted result delivered
    task automatic wait_idle();
        while (!(bytes_accepted == bytes_queued && positions_due.size() == 0))
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_piece_limit(logic [PIECE_W-1:0] value);
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        piece_limit = value;
    endtask

    // -------------------------------------------------------------- processes
    initial
    begin
        forever #1 clk = ~clk;
    end

    // cycle guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Driver: a new byte request once the current one has been taken.
    // Valid stays up while stalled, payload held.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || bytes_accepted == bytes_offered)
        begin
            if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_req = byte_backlog.pop_front();
                in_valid <= 1'b1;
                text_byte <= next_req.text_byte;
                line_end <= next_req.line_end;
                bytes_offered++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, and one long hold-off once armed
    always @(negedge clk)
    begin
        if (hold_arm && !hold_done)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: predict on accepted bytes, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                scan_char(text_byte, line_end);
                bytes_accepted++;
            end
            if (out_valid && !out_stall)
            begin
                check_position();
                results_seen++;
            end
        end
    end

    // Main sequence
    initial
    begin
        restart_scan();
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed lines at the reset limit of seven men
        add_text("8/8/8/8/8/8/8/8 w - -");
        close_line();
        add_text("4k3/8/8/8/8/8/8/4K3 b KQkq e3 0");
        close_line();
        add_text("rnbqkbnr/pppppppp/8/8/8/8/PPPPPPPP/RNBQKBNR w - h8 1023");
        close_line();
        add_text("7k/8/8/8/8/8/8/K7 w  a1 5");                 // empty castling field
        close_line();
        add_text("8/8/8/8/8/8/8/8 b - - ");                    // whitespace, plus, saturation
        line_buf.push_back(CH_TAB);
        line_buf.push_back(CH_CR);
        add_text("+99999");
        close_line();
        add_text("1111111k/8/8/8/8/8/8/8 b - - -7");           // minus on nonzero count
        close_line();
        add_text("8/8/8/8/8/8/8/8 w - - -");                   // ends on the sign
        close_line();
        add_text("8/8/8/8/8/8/8/8 w Qk -x");                   // text glued to en passant
        close_line();
        add_text("8/8/8/8/8/8/8/8 w - - 12 34");               // text after the count
        close_line();
        add_text("8/8/8/8/8/8/8/8 w - - ");                    // zero byte ends the text
        line_buf.push_back(CH_NUL);
        line_buf.push_back(8'hFF);
        close_line();
        add_text("8/8");                                       // zero byte too early
        line_buf.push_back(CH_NUL);
        add_text("/8");
        close_line();
        add_text("8/8/8/8 w");                                 // line ends too early
        close_line();
        add_text("k8/8/8/8/8/8/8/8 w - -");                    // rank overflow, rest ignored
        close_line();
        add_text("8/8/8/8/8/8/8/8 x - -");                     // bad side letter
        close_line();
        wait_idle();

        // sender mostly busy, receiver mostly stalled; nothing accepted with men
        load_piece_limit(7'd0);
        send_idle_pct = 20;
        recv_stall_pct = 88;
        run_lines(200, 5);
        wait_idle();

        // roles swapped, everything up to a full board fits
        load_piece_limit(7'd64);
        send_idle_pct = 88;
        recv_stall_pct = 20;
        run_lines(200, 5);
        wait_idle();

        // back to back
        load_piece_limit(7'd63);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_lines(200, 5);
        wait_idle();

        // long receiver hold-off while bytes keep coming: the result register
        // fills and the next line_end byte is stalled
        load_piece_limit(7'($urandom_range(62, 1)));
        hold_arm = 1'b1;
        run_lines(200, 5);
        wait_idle();

        repeat (10) @(negedge clk);
        if (positions_due.size() != 0)
            note_mismatch("results never delivered", 64'd0, 64'(positions_due.size()));
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== fen_position_parser.f =====
rtl/fpp_pkg.sv
rtl/fpp_in_stage.sv
rtl/fpp_parser.sv
rtl/fen_position_parser.sv
dv/tb_fen_position_parser.sv
